// ----- hdl/first_fit_block_allocator_core_defines.svh -----
// Assertion macros shared by the allocator modules.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FFBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");

// Next-cycle implication, checked outside reset.
`define FFBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");

`endif

// ----- hdl/ffba_pkg.sv -----
`default_nettype none
package ffba_pkg;

	localparam int ALIGN      = 8;
	localparam int ALIGN_W    = $clog2(ALIGN);
	localparam int POOL_UNITS = 4096;
	localparam int TAG_DEPTH  = (POOL_UNITS + ALIGN - 1) / ALIGN;
	localparam int SLOT_W     = $clog2(TAG_DEPTH);
	localparam int SIZE_W     = 13;
	localparam int TAG_W      = SIZE_W + 1;
	localparam int REQ_W      = 14;
	localparam int H_W        = 13;
	localparam int OFF_W      = 12;
	localparam int STAT_W     = 2;

	localparam logic [STAT_W-1:0] ST_ALLOCATED = 2'd0;
	localparam logic [STAT_W-1:0] ST_FAIL      = 2'd1;
	localparam logic [STAT_W-1:0] ST_FORMATTED = 2'd2;

	localparam logic OP_FORMAT = 1'b0;

	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_IDLE      = 4'd0;
	localparam step_t STEP_DISP      = 4'd1;
	localparam step_t STEP_CHECK     = 4'd2;
	localparam step_t STEP_EVAL      = 4'd3;
	localparam step_t STEP_TAKE      = 4'd4;
	localparam step_t STEP_SPLIT     = 4'd5;
	localparam step_t STEP_DONE_OK   = 4'd6;
	localparam step_t STEP_FMT       = 4'd7;
	localparam step_t STEP_DONE_FMT  = 4'd8;
	localparam step_t STEP_DONE_FAIL = 4'd9;

	typedef enum logic [2:0] {
		COND_ALWAYS   = 3'd0,
		COND_ACCEPT   = 3'd1,
		COND_FORMAT   = 3'd2,
		COND_WALK_END = 3'd3,
		COND_NOFIT    = 3'd4,
		COND_EXACT    = 3'd5,
		COND_OUT_FREE = 3'd6
	} cond_t;

	typedef enum logic [1:0] {
		WR_NONE  = 2'd0,
		WR_FMT   = 2'd1,
		WR_TAKE  = 2'd2,
		WR_SPLIT = 2'd3
	} wr_sel_t;

	typedef struct packed {
		logic              in_ready;
		logic              latch_in;
		logic              eval;
		wr_sel_t           wr_sel;
		logic              set_fmt;
		logic              emit;
		logic [STAT_W-1:0] status;
	} act_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		step_t target;
		logic  hold;
	} uword_t;

	typedef struct packed {
		logic fmt_op;
		logic walk_end;
		logic fit;
		logic split;
		logic out_free;
	} flags_t;

	// Control store. A step jumps to target when its condition holds;
	// otherwise it either stays put (hold) or falls through to the next step.
	function automatic uword_t ucode(input step_t step);
		uword_t w;
		w            = '0;
		w.cond       = COND_ALWAYS;
		w.target     = STEP_IDLE;
		w.act.wr_sel = WR_NONE;
		w.act.status = ST_FAIL;
		unique case (step)
			STEP_IDLE: begin
				w.act.in_ready = 1'b1;
				w.act.latch_in = 1'b1;
				w.cond         = COND_ACCEPT;
				w.target       = STEP_DISP;
				w.hold         = 1'b1;
			end
			STEP_DISP: begin
				w.cond   = COND_FORMAT;
				w.target = STEP_FMT;
			end
			STEP_CHECK: begin
				w.cond   = COND_WALK_END;
				w.target = STEP_DONE_FAIL;
			end
			STEP_EVAL: begin
				w.act.eval = 1'b1;
				w.cond     = COND_NOFIT;
				w.target   = STEP_CHECK;
			end
			STEP_TAKE: begin
				w.act.wr_sel = WR_TAKE;
				w.cond       = COND_EXACT;
				w.target     = STEP_DONE_OK;
			end
			STEP_SPLIT: begin
				w.act.wr_sel = WR_SPLIT;
				w.target     = STEP_DONE_OK;
			end
			STEP_DONE_OK: begin
				w.act.emit   = 1'b1;
				w.act.status = ST_ALLOCATED;
				w.cond       = COND_OUT_FREE;
				w.hold       = 1'b1;
			end
			STEP_FMT: begin
				w.act.wr_sel  = WR_FMT;
				w.act.set_fmt = 1'b1;
				w.target      = STEP_DONE_FMT;
			end
			STEP_DONE_FMT: begin
				w.act.emit   = 1'b1;
				w.act.status = ST_FORMATTED;
				w.cond       = COND_OUT_FREE;
				w.hold       = 1'b1;
			end
			STEP_DONE_FAIL: begin
				w.act.emit   = 1'b1;
				w.act.status = ST_FAIL;
				w.cond       = COND_OUT_FREE;
				w.hold       = 1'b1;
			end
			default: begin
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/ffba_ram.sv -----
`default_nettype none
module ffba_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- hdl/ffba_seq.sv -----
`default_nettype none
`include "first_fit_block_allocator_core_defines.svh"
module ffba_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire ffba_pkg::flags_t flags,
	output ffba_pkg::act_t       act
);

	ffba_pkg::step_t  step_q;
	ffba_pkg::step_t  step_d;
	ffba_pkg::uword_t uw;
	logic             cond_ok;

	assign uw  = ffba_pkg::ucode(step_q);
	assign act = uw.act;

	always_comb begin
		case (uw.cond)
			ffba_pkg::COND_ALWAYS:   cond_ok = 1'b1;
			ffba_pkg::COND_ACCEPT:   cond_ok = in_valid;
			ffba_pkg::COND_FORMAT:   cond_ok = flags.fmt_op;
			ffba_pkg::COND_WALK_END: cond_ok = flags.walk_end;
			ffba_pkg::COND_NOFIT:    cond_ok = !flags.fit;
			ffba_pkg::COND_EXACT:    cond_ok = !flags.split;
			ffba_pkg::COND_OUT_FREE: cond_ok = flags.out_free;
			default:                 cond_ok = 1'b1;
		endcase
	end

	always_comb begin
		if (cond_ok) begin
			step_d = uw.target;
		end else if (uw.hold) begin
			step_d = step_q;
		end else begin
			step_d = step_q + ffba_pkg::STEP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ffba_pkg::STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// An accepted beat always moves the program on to dispatch.
	`FFBA_ASSERT_NEXT(a_accept_dispatch, clk, arst_n, in_valid && act.in_ready,
		step_q == ffba_pkg::STEP_DISP)

endmodule
`default_nettype wire

// ----- hdl/ffba_dp.sv -----
`default_nettype none
`include "first_fit_block_allocator_core_defines.svh"
module ffba_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ffba_pkg::act_t               act,
	input  wire logic                         in_valid,
	input  wire logic                         opcode,
	input  wire logic [ffba_pkg::SIZE_W-1:0]  request_size,
	input  wire logic                         cfg_valid,
	input  wire logic [ffba_pkg::SIZE_W-1:0]  pool_size,
	input  wire logic                         out_ready,
	output logic                              out_valid,
	output logic [ffba_pkg::STAT_W-1:0]       status,
	output logic [ffba_pkg::OFF_W-1:0]        block_offset,
	output ffba_pkg::flags_t                  flags
);

	localparam logic [ffba_pkg::ALIGN_W-1:0] LOW_ZERO = '0;

	logic [ffba_pkg::SIZE_W-1:0] pool_size_q;
	logic [ffba_pkg::H_W-1:0]    pool_units_q;
	logic                        formatted_q;
	logic                        opcode_q;
	logic [ffba_pkg::REQ_W-1:0]  req_q;
	logic [ffba_pkg::H_W-1:0]    h_q;
	logic [ffba_pkg::SIZE_W-1:0] size_q;
	logic                        out_valid_q;
	logic [ffba_pkg::STAT_W-1:0] status_q;
	logic [ffba_pkg::OFF_W-1:0]  offset_q;

	logic [ffba_pkg::REQ_W-1:0]  req_sum;
	logic [ffba_pkg::REQ_W-1:0]  req_round;
	logic [ffba_pkg::H_W-1:0]    units_clamp;
	logic [ffba_pkg::H_W-1:0]    units_fmt;
	logic [ffba_pkg::TAG_W-1:0]  rdata;
	logic [ffba_pkg::SIZE_W-1:0] rd_size;
	logic                        fit;
	logic [ffba_pkg::SIZE_W-1:0] rem;
	logic                        split;
	logic [ffba_pkg::H_W-1:0]    h_data;
	logic [ffba_pkg::REQ_W-1:0]  split_at;
	logic                        out_free;
	logic                        we;
	logic [ffba_pkg::SLOT_W-1:0] waddr;
	logic [ffba_pkg::TAG_W-1:0]  wdata;

	// Round the request up to the alignment; an empty request counts as one unit of it.
	assign req_sum = {1'b0, request_size} + ffba_pkg::REQ_W'(ffba_pkg::ALIGN - 1);
	assign req_round = (request_size == '0) ? ffba_pkg::REQ_W'(ffba_pkg::ALIGN)
		: {req_sum[ffba_pkg::REQ_W-1:ffba_pkg::ALIGN_W], LOW_ZERO};

	always_comb begin
		if (pool_size_q > ffba_pkg::SIZE_W'(ffba_pkg::POOL_UNITS)) begin
			units_clamp = ffba_pkg::H_W'(ffba_pkg::POOL_UNITS);
		end else begin
			units_clamp = pool_size_q;
		end
		units_fmt = {units_clamp[ffba_pkg::H_W-1:ffba_pkg::ALIGN_W], LOW_ZERO};
		if (units_fmt < ffba_pkg::H_W'(ffba_pkg::ALIGN)) begin
			units_fmt = ffba_pkg::H_W'(ffba_pkg::ALIGN);
		end
	end

	assign rd_size  = rdata[ffba_pkg::TAG_W-1:1];
	assign fit      = !rdata[0] && ({1'b0, rd_size} >= req_q);
	assign rem      = size_q - req_q[ffba_pkg::SIZE_W-1:0];
	assign split    = rem >= ffba_pkg::SIZE_W'(ffba_pkg::ALIGN);
	assign h_data   = h_q + ffba_pkg::H_W'(ffba_pkg::ALIGN);
	assign split_at = {1'b0, h_data} + req_q;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		we    = 1'b1;
		waddr = h_q[ffba_pkg::ALIGN_W +: ffba_pkg::SLOT_W];
		wdata = {size_q, 1'b1};
		case (act.wr_sel)
			ffba_pkg::WR_FMT: begin
				waddr = '0;
				wdata = {units_fmt - ffba_pkg::H_W'(ffba_pkg::ALIGN), 1'b0};
			end
			ffba_pkg::WR_TAKE: begin
				// Without a split the block keeps its whole size.
				if (split) begin
					wdata = {req_q[ffba_pkg::SIZE_W-1:0], 1'b1};
				end
			end
			ffba_pkg::WR_SPLIT: begin
				waddr = split_at[ffba_pkg::ALIGN_W +: ffba_pkg::SLOT_W];
				wdata = {rem - ffba_pkg::SIZE_W'(ffba_pkg::ALIGN), 1'b0};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	ffba_ram #(
		.WIDTH(ffba_pkg::TAG_W),
		.DEPTH(ffba_pkg::TAG_DEPTH)
	) u_tags (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(h_q[ffba_pkg::ALIGN_W +: ffba_pkg::SLOT_W]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q  <= ffba_pkg::SIZE_W'(ffba_pkg::POOL_UNITS);
			pool_units_q <= '0;
			formatted_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				pool_size_q <= pool_size;
			end
			if (act.set_fmt) begin
				pool_units_q <= units_fmt;
				formatted_q  <= 1'b1;
			end
			if (act.emit && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act.latch_in && in_valid) begin
			opcode_q <= opcode;
			req_q    <= req_round;
			h_q      <= '0;
		end else if (act.eval) begin
			size_q <= rd_size;
			// A miss steps to the next header; a hit keeps the pointer on the block.
			if (!fit) begin
				h_q <= h_data + rd_size;
			end
		end
		if (act.emit && out_free) begin
			status_q <= act.status;
			offset_q <= (act.status == ffba_pkg::ST_ALLOCATED) ? h_data[ffba_pkg::OFF_W-1:0]
				: '0;
		end
	end

	assign flags.fmt_op   = opcode_q == ffba_pkg::OP_FORMAT;
	assign flags.walk_end = !formatted_q || (h_q >= pool_units_q);
	assign flags.fit      = fit;
	assign flags.split    = split;
	assign flags.out_free = out_free;

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign block_offset = offset_q;

	// A granted block can only come from a formatted pool.
	`FFBA_ASSERT_NOW(a_alloc_formatted, clk, arst_n,
		out_valid_q && (status_q == ffba_pkg::ST_ALLOCATED), formatted_q)
	// Any result other than a grant carries a zero offset.
	`FFBA_ASSERT_NOW(a_offset_zero, clk, arst_n,
		out_valid_q && (status_q != ffba_pkg::ST_ALLOCATED), offset_q == '0)
	// The walk pointer never overruns the formatted pool while evaluating.
	`FFBA_ASSERT_NOW(a_walk_bound, clk, arst_n, act.eval, h_q < pool_units_q)

endmodule
`default_nettype wire

// ----- hdl/first_fit_block_allocator_core.sv -----
// First-fit block allocator over a pool of 4096 units kept as a chain of 8-unit
// headers in a 512 x 14 tag RAM. Write pool_size on the cfg channel, send a
// format beat (opcode 0) to lay the pool out as one free block, then send
// allocate beats (opcode 1). Each beat returns one result: status 2 on format,
// status 0 with the data offset on a grant, status 1 when nothing fits or the
// pool is unformatted. One item is worked at a time under a microcoded
// sequencer. A format runs dispatch, the format write and the result step. An
// allocation runs dispatch, a check and an evaluation step per header visited,
// the take step, a split step when the block is split, and the result step. Each
// header costs one registered tag RAM read. The tag RAM needs no clearing after reset.
`default_nettype none
module first_fit_block_allocator_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [ffba_pkg::SIZE_W-1:0]  pool_size,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         opcode,
	input  wire logic [ffba_pkg::SIZE_W-1:0]  request_size,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [ffba_pkg::STAT_W-1:0]       status,
	output logic [ffba_pkg::OFF_W-1:0]        block_offset
);

	ffba_pkg::act_t   act;
	ffba_pkg::flags_t flags;

	assign cfg_ready = 1'b1;
	assign in_ready  = act.in_ready;

	ffba_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.flags   (flags),
		.act     (act)
	);

	ffba_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.act         (act),
		.in_valid    (in_valid),
		.opcode      (opcode),
		.request_size(request_size),
		.cfg_valid   (cfg_valid),
		.pool_size   (pool_size),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.status      (status),
		.block_offset(block_offset),
		.flags       (flags)
	);

endmodule
`default_nettype wire
